[rtl/ihx_enc_pkg.sv]
package ihx_enc_pkg;

  // record geometry
  localparam int RECORD_BYTES = 16;
  localparam int CNT_W        = $clog2(RECORD_BYTES + 1);
  localparam int ADDR_W       = 17;
  localparam int LEN_W        = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  // one work command for the back end: everything one input item produces
  typedef struct packed {
    logic        ext_on;     // emit extended segment record, base 0x1000
    logic        ext_off;    // emit extended segment record, base 0
    logic        hdr;        // item opens a record
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  data;
    logic        close;      // item closes a record
    logic [7:0]  cksum;
  } cmd_t;

  // back end text sequencer phases
  typedef enum logic [2:0] {
    BK_START,
    BK_EXT,
    BK_HDR,
    BK_DATA,
    BK_SUM
  } bk_phase_t;

  // uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else             c = 8'h37 + {4'd0, nib};
    return c;
  endfunction

  // fixed extended segment records, newline at position 15
  function automatic logic [7:0] ext_char(input logic on, input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = CH_COLON;
      4'd1:    c = "0";
      4'd2:    c = "2";
      4'd3:    c = "0";
      4'd4:    c = "0";
      4'd5:    c = "0";
      4'd6:    c = "0";
      4'd7:    c = "0";
      4'd8:    c = "2";
      4'd9:    c = on ? "1" : "0";
      4'd10:   c = "0";
      4'd11:   c = "0";
      4'd12:   c = "0";
      4'd13:   c = on ? "E" : "F";
      4'd14:   c = "C";
      default: c = CH_NEWLINE;
    endcase
    return c;
  endfunction

endpackage

[rtl/intel_hex_record_encoder_core.sv]
// Intel HEX record encoder.
// Input channel: one data byte per item, with push/full. in_block_start
// marks the first byte of a block and loads in_block_address and
// in_block_length. Bytes with no block open, and empty blocks, make no text.
// Result channel: one ASCII character per item, with empty/pop. The last
// character produced by an input byte carries out_run_end.
// A byte expands to 2 characters, plus 9 for a record header, 3 for the
// checksum and newline, and 16 for an extended segment record; the back
// end sends one character per cycle while pop keeps up, so a byte makes
// 2 to 30 characters there, about 2.75 on average with full records.
// The front end takes a byte every cycle while its 4-entry command queue
// has room; an accepted item is written into the queue, and its first
// character reaches the result ports through the output register.
// When pop stays low the current character holds; the back end stops, the
// queue fills and full rises. Reset empties the queue and output register
// and clears the extended segment flag and all record state.
module intel_hex_record_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_start,
  input  logic [16:0] in_block_address,
  input  logic [15:0] in_block_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_text_char,
  output logic        out_run_end
);
  import ihx_enc_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_full, q_empty, q_pop, in_acc;

  assign full   = q_full;
  assign in_acc = push && !q_full;

  // front: byte classification and record state
  ihx_enc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_acc),
    .in_data_byte     (in_data_byte),
    .in_block_start   (in_block_start),
    .in_block_address (in_block_address),
    .in_block_length  (in_block_length),
    .cmd_push         (f_push),
    .cmd              (f_cmd)
  );

  // command queue
  ihx_enc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_cmd  (f_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (q_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: text generation
  ihx_enc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_avail     (!q_empty),
    .cmd           (q_cmd),
    .cmd_pop       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_text_char (out_text_char),
    .out_run_end   (out_run_end)
  );

endmodule

[rtl/ihx_enc_front.sv]
module ihx_enc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_block_start,
  input  logic [16:0]               in_block_address,
  input  logic [15:0]               in_block_length,
  output logic                      cmd_push,
  output ihx_enc_pkg::cmd_t         cmd
);
  import ihx_enc_pkg::*;

  logic              ext_r,   ext_nxt;
  logic [ADDR_W-1:0] addr_r,  addr_nxt;
  logic [LEN_W-1:0]  rem_r,   rem_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [CNT_W-1:0]  idx_r,   idx_nxt;
  logic [7:0]        sum_r,   sum_nxt;

  logic [ADDR_W-1:0] e_addr;
  logic [LEN_W-1:0]  e_rem;
  logic [CNT_W-1:0]  e_cnt, e_idx, cnt_sel, idx_inc;
  logic [7:0]        e_sum, sum_base, sum_new;
  logic              opens, ext_on, ext_off, close, live;

  // block start overrides the running record state
  always_comb begin
    e_addr = in_block_start ? in_block_address : addr_r;
    e_rem  = in_block_start ? in_block_length  : rem_r;
    e_cnt  = in_block_start ? '0 : cnt_r;
    e_idx  = in_block_start ? '0 : idx_r;
    e_sum  = in_block_start ? '0 : sum_r;
  end

  // classify the item
  always_comb begin
    live    = (e_rem != '0);
    opens   = (e_idx == '0);
    ext_on  = opens && !ext_r && e_addr[ADDR_W-1];
    ext_off = opens && ext_r && !e_addr[ADDR_W-1];
    if (!opens)
      cnt_sel = e_cnt;
    else if (e_rem < LEN_W'(RECORD_BYTES))
      cnt_sel = e_rem[CNT_W-1:0];
    else
      cnt_sel = CNT_W'(RECORD_BYTES);
    sum_base = opens ? (8'(cnt_sel) + e_addr[15:8] + e_addr[7:0]) : e_sum;
    sum_new  = sum_base + in_data_byte;
    idx_inc  = e_idx + CNT_W'(1);
    close    = (idx_inc >= cnt_sel);
  end

  // command for the back end
  always_comb begin
    cmd_push      = in_valid && live;
    cmd.ext_on    = ext_on;
    cmd.ext_off   = ext_off;
    cmd.hdr       = opens;
    cmd.rec_count = 8'(cnt_sel);
    cmd.rec_addr  = e_addr[15:0];
    cmd.data      = in_data_byte;
    cmd.close     = close;
    cmd.cksum     = 8'd0 - sum_new;
  end

  // next record state
  always_comb begin
    ext_nxt  = ext_r;
    addr_nxt = e_addr;
    rem_nxt  = e_rem;
    cnt_nxt  = e_cnt;
    idx_nxt  = e_idx;
    sum_nxt  = e_sum;
    if (live) begin
      if (ext_on)  ext_nxt = 1'b1;
      if (ext_off) ext_nxt = 1'b0;
      rem_nxt = e_rem - LEN_W'(1);
      if (close) begin
        addr_nxt = e_addr + ADDR_W'(RECORD_BYTES);
        cnt_nxt  = '0;
        idx_nxt  = '0;
        sum_nxt  = '0;
      end else begin
        cnt_nxt  = cnt_sel;
        idx_nxt  = idx_inc;
        sum_nxt  = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r  <= 1'b0;
      addr_r <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
      sum_r  <= '0;
    end else if (in_valid) begin
      ext_r  <= ext_nxt;
      addr_r <= addr_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

[rtl/ihx_enc_cmdq.sv]
module ihx_enc_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ihx_enc_pkg::cmd_t wr_cmd,
  input  logic              rd_en,
  output ihx_enc_pkg::cmd_t rd_cmd,
  output logic              q_full,
  output logic              q_empty
);
  import ihx_enc_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r,    cnt_nxt;
  logic              do_wr, do_rd;

  // occupancy and pointers
  always_comb begin
    q_full     = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
    q_empty    = (cnt_r == '0);
    do_wr      = wr_en && !q_full;
    do_rd      = rd_en && !q_empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    rd_cmd     = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) q_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

[rtl/ihx_enc_back.sv]
module ihx_enc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_avail,
  input  ihx_enc_pkg::cmd_t cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_text_char,
  output logic              out_run_end
);
  import ihx_enc_pkg::*;

  bk_phase_t  ph_r,  ph_nxt, cur_ph;
  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_end_r;
  logic       adv, fire, seg_end, done;
  logic [7:0] ch;
  logic [3:0] nib;

  assign adv  = !out_valid_r || pop;
  assign fire = cmd_avail && adv;

  // phase in effect for the head command
  always_comb begin
    if (ph_r == BK_START) begin
      if (cmd.ext_on || cmd.ext_off) cur_ph = BK_EXT;
      else if (cmd.hdr)              cur_ph = BK_HDR;
      else                           cur_ph = BK_DATA;
    end else begin
      cur_ph = ph_r;
    end
  end

  // character for the current phase and position
  always_comb begin
    ch      = CH_NEWLINE;
    nib     = 4'd0;
    seg_end = 1'b0;
    done    = 1'b0;
    case (cur_ph)
      BK_EXT: begin
        ch      = ext_char(cmd.ext_on, pos_r);
        seg_end = (pos_r == 4'd15);
      end
      BK_HDR: begin
        case (pos_r)
          4'd1:    nib = cmd.rec_count[7:4];
          4'd2:    nib = cmd.rec_count[3:0];
          4'd3:    nib = cmd.rec_addr[15:12];
          4'd4:    nib = cmd.rec_addr[11:8];
          4'd5:    nib = cmd.rec_addr[7:4];
          4'd6:    nib = cmd.rec_addr[3:0];
          default: nib = 4'd0;
        endcase
        ch      = (pos_r == 4'd0) ? CH_COLON : hex_char(nib);
        seg_end = (pos_r == 4'd8);
      end
      BK_DATA: begin
        nib     = (pos_r == 4'd0) ? cmd.data[7:4] : cmd.data[3:0];
        ch      = hex_char(nib);
        seg_end = (pos_r == 4'd1);
        done    = seg_end && !cmd.close;
      end
      BK_SUM: begin
        nib     = (pos_r == 4'd0) ? cmd.cksum[7:4] : cmd.cksum[3:0];
        ch      = (pos_r == 4'd2) ? CH_NEWLINE : hex_char(nib);
        seg_end = (pos_r == 4'd2);
        done    = seg_end;
      end
      default: begin
        ch = CH_NEWLINE;
      end
    endcase
  end

  // next phase and position
  always_comb begin
    ph_nxt  = cur_ph;
    pos_nxt = pos_r + 4'd1;
    if (done) begin
      ph_nxt  = BK_START;
      pos_nxt = 4'd0;
    end else if (seg_end) begin
      pos_nxt = 4'd0;
      case (cur_ph)
        BK_EXT:  ph_nxt = BK_HDR;
        BK_HDR:  ph_nxt = BK_DATA;
        BK_DATA: ph_nxt = BK_SUM;
        default: ph_nxt = BK_START;
      endcase
    end
  end

  assign cmd_pop = fire && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= BK_START;
      pos_r <= 4'd0;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      pos_r <= pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cmd_avail;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r <= ch;
      out_end_r  <= done;
    end
  end

  assign empty         = !out_valid_r;
  assign out_text_char = out_char_r;
  assign out_run_end   = out_end_r;

endmodule

[rtl/ihx_enc_checker.sv]
module ihx_enc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_text_char,
  input logic        out_run_end
);

  logic is_hex, is_nl, is_colon;

  assign is_nl    = (out_text_char == 8'd10);
  assign is_colon = (out_text_char == 8'h3A);
  assign is_hex   = ((out_text_char >= 8'h30) && (out_text_char <= 8'h39)) ||
                    ((out_text_char >= 8'h41) && (out_text_char <= 8'h46));

  // reset leaves both channels idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("channels not idle after reset");

  // the input side only fills up after an offered item
  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without an offered item");

  // a waiting character holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_text_char) && $stable(out_run_end))
    else $error("result changed while stalled");

  // only hex text characters appear
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> is_hex || is_nl || is_colon)
    else $error("character outside hex text set");

  // an item always ends on a data digit or a newline
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_run_end |-> is_hex || is_nl)
    else $error("item ends on a colon");

endmodule

bind intel_hex_record_encoder_core ihx_enc_checker u_ihx_enc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_text_char (out_text_char),
  .out_run_end   (out_run_end)
);
